### rtl/gfq_pkg.sv
// Shared types and codes for the grouped FIFO (team queue).
// No dependencies; used by gfq_out_reg and grouped_fifo_team_queue_top.
package gfq_pkg;

    localparam int ELEM_W   = 12;
    localparam int TEAM_W   = 8;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_ASSIGN  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ELEM_W-1:0]   element;
        logic                valid;
    } result_t;

endpackage

### rtl/gfq_out_reg.sv
// Result output register for the grouped FIFO: holds one result beat until taken.
// Depends on gfq_pkg.
module gfq_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  gfq_pkg::result_t result,
    output logic             can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata   // out_valid, out_element, status, zero pad
);

    logic             full_reg;
    logic             full_next;
    gfq_pkg::result_t data_reg;

    assign can_load  = !full_reg || m_tready;
    assign full_next = load || (full_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = full_reg;
    assign m_tdata  = {1'b0, data_reg.status, data_reg.element, data_reg.valid};

endmodule

### rtl/grouped_fifo_team_queue_top.sv
// Top level of the grouped FIFO (team queue): memories, sequencer and result port.
// Depends on gfq_pkg and gfq_out_reg.
//
// The block handles one request beat at a time. An enqueue and a dequeue each
// walk a chain of registered reads through the membership, free-stack, team,
// ring and slot memories before the result; an assign or a rejected enqueue or
// dequeue goes straight to the result. A clear, and the start after reset,
// sweep the membership map and the team table one entry a cycle, during which
// no request is taken; the result of a clear follows the sweep. Storage slots
// are handed out from a free stack of returned slots while it holds any and
// otherwise from a never-used pool counted by a watermark, so the free stack
// needs no filling. A new request is accepted while the previous result still
// waits in the output register.
module grouped_fifo_team_queue_top #(
    parameter int NUM_ELEMENTS = 4096,
    parameter int NUM_TEAMS    = 256,
    parameter int CAPACITY     = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // req_type[1:0], element_id[13:2], team_id[21:14], pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // out_valid[0], out_element[12:1], status[14:13], pad
);

    localparam int EW       = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int TW       = (NUM_TEAMS > 1) ? $clog2(NUM_TEAMS) : 1;
    localparam int SW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SWEEP_N  = (NUM_ELEMENTS > NUM_TEAMS) ? NUM_ELEMENTS : NUM_TEAMS;
    localparam int CW       = $clog2(SWEEP_N);
    localparam int TMW      = SW + SW + SW + 1;
    localparam int ELEM_W_L = gfq_pkg::ELEM_W;

    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ENQ1  = 4'd2;
    localparam logic [3:0] S_ENQ2  = 4'd3;
    localparam logic [3:0] S_DEQ1  = 4'd4;
    localparam logic [3:0] S_DEQ2  = 4'd5;
    localparam logic [3:0] S_DEQ3  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;

    // Team table word: head slot, tail slot and element count.
    typedef struct packed {
        logic [SW-1:0] head;
        logic [SW-1:0] tail;
        logic [SW:0]   size;
    } team_word_t;

    // Memories.
    logic [TW-1:0]  toe_mem  [NUM_ELEMENTS];
    logic [ELEM_W_L-1:0] se_mem [CAPACITY];
    logic [SW-1:0]  sn_mem   [CAPACITY];
    logic [SW-1:0]  fs_mem   [CAPACITY];
    logic [TMW-1:0] tm_mem   [NUM_TEAMS];
    logic [TW-1:0]  ring_mem [NUM_TEAMS];

    // Control registers. The report flag tells a sweep started by a clear, which
    // owes a result beat, from the sweep after reset, which owes none.
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] sweep_reg, sweep_next;
    logic          report_reg, report_next;
    logic [SW:0]   fresh_reg, fresh_next;
    logic [SW:0]   rcount_reg, rcount_next;
    logic [TW-1:0] ohead_reg, ohead_next;
    logic [TW-1:0] otail_reg, otail_next;
    logic [TW:0]   ocount_reg, ocount_next;

    // Input fields.
    logic [gfq_pkg::REQ_W-1:0]  in_req;
    logic [gfq_pkg::ELEM_W-1:0] in_elem;
    logic [gfq_pkg::TEAM_W-1:0] in_team;
    logic                       in_elem_ok;
    logic                       in_team_ok;
    logic                       accept;

    assign in_req     = s_tdata[1:0];
    assign in_elem    = s_tdata[13:2];
    assign in_team    = s_tdata[21:14];
    assign in_elem_ok = 32'(in_elem) < NUM_ELEMENTS;
    assign in_team_ok = 32'(in_team) < NUM_TEAMS;
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;

    // Payload registers.
    logic [gfq_pkg::ELEM_W-1:0] elem_reg;
    logic                       elem_ok_reg;
    logic [TW-1:0]              t_reg, t_next;
    logic [SW-1:0]              slot_reg, slot_next;
    team_word_t                 tw_reg;
    gfq_pkg::result_t           res_reg, res_next;

    // Read data.
    logic [TW-1:0]       toe_rdata;
    logic [ELEM_W_L-1:0] se_rdata;
    logic [SW-1:0]       sn_rdata;
    logic [SW-1:0]       fs_rdata;
    team_word_t          tm_rdata;
    logic [TW-1:0]       ring_rdata;

    // Read addresses and write controls.
    logic [TW-1:0] tm_raddr;
    logic          toe_we, tm_we, fs_we, se_we, sn_we, ring_we;
    logic [EW-1:0] toe_waddr;
    logic [TW-1:0] toe_wdata;
    logic [TW-1:0] tm_waddr;
    team_word_t    tm_wdata;
    logic [SW-1:0] sn_waddr;
    logic          full_now;
    logic          out_can_load;
    logic          out_load;
    team_word_t    tm_new;
    logic [SW:0]   size_dec;

    assign full_now = (rcount_reg == '0) && (fresh_reg == (SW+1)'(CAPACITY));
    assign size_dec = tw_reg.size - 1'b1;

    always_comb begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        report_next = report_reg;
        fresh_next  = fresh_reg;
        rcount_next = rcount_reg;
        ohead_next  = ohead_reg;
        otail_next  = otail_reg;
        ocount_next = ocount_reg;
        t_next      = t_reg;
        slot_next   = slot_reg;
        res_next    = res_reg;
        tm_raddr    = t_reg;
        toe_we      = 1'b0;
        toe_waddr   = EW'(in_elem);
        toe_wdata   = TW'(in_team);
        tm_we       = 1'b0;
        tm_waddr    = t_reg;
        tm_wdata    = '0;
        fs_we       = 1'b0;
        se_we       = 1'b0;
        sn_we       = 1'b0;
        sn_waddr    = tw_reg.tail;
        ring_we     = 1'b0;
        out_load    = 1'b0;
        tm_new      = tw_reg;
        case (state_reg)
            S_SWEEP: begin
                // Clear one membership entry and one team entry per cycle.
                toe_we    = 32'(sweep_reg) < NUM_ELEMENTS;
                toe_waddr = EW'(sweep_reg);
                toe_wdata = '0;
                tm_we     = 32'(sweep_reg) < NUM_TEAMS;
                tm_waddr  = TW'(sweep_reg);
                tm_wdata  = '0;
                if (sweep_reg == CW'(SWEEP_N - 1)) begin
                    sweep_next  = '0;
                    report_next = 1'b0;
                    state_next  = report_reg ? S_FIN : S_IDLE;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    res_next = '{status: gfq_pkg::STAT_OK, element: '0, valid: 1'b0};
                    case (in_req)
                        gfq_pkg::REQ_ASSIGN: begin
                            toe_we     = in_elem_ok && in_team_ok;
                            state_next = S_FIN;
                        end
                        gfq_pkg::REQ_ENQUEUE: begin
                            if (full_now) begin
                                res_next.status = gfq_pkg::STAT_FULL;
                                state_next      = S_FIN;
                            end else begin
                                state_next = S_ENQ1;
                            end
                        end
                        gfq_pkg::REQ_DEQUEUE: begin
                            if (ocount_reg == '0) begin
                                res_next.status = gfq_pkg::STAT_EMPTY;
                                state_next      = S_FIN;
                            end else begin
                                state_next = S_DEQ1;
                            end
                        end
                        default: begin
                            fresh_next  = '0;
                            rcount_next = '0;
                            ohead_next  = '0;
                            otail_next  = '0;
                            ocount_next = '0;
                            sweep_next  = '0;
                            report_next = 1'b1;
                            state_next  = S_SWEEP;
                        end
                    endcase
                end
            end
            S_ENQ1: begin
                t_next   = elem_ok_reg ? toe_rdata : '0;
                tm_raddr = t_next;
                if (rcount_reg != '0) begin
                    slot_next   = fs_rdata;
                    rcount_next = rcount_reg - 1'b1;
                end else begin
                    slot_next  = fresh_reg[SW-1:0];
                    fresh_next = fresh_reg + 1'b1;
                end
                state_next = S_ENQ2;
            end
            S_ENQ2: begin
                se_we  = 1'b1;
                tm_new = tm_rdata;
                if (tm_rdata.size == '0) begin
                    tm_new.head = slot_reg;
                    ring_we     = 1'b1;
                    otail_next  = (otail_reg == TW'(NUM_TEAMS - 1)) ? '0 : otail_reg + 1'b1;
                    ocount_next = ocount_reg + 1'b1;
                end else begin
                    sn_we    = 1'b1;
                    sn_waddr = tm_rdata.tail;
                end
                tm_new.tail = slot_reg;
                tm_new.size = tm_rdata.size + 1'b1;
                tm_we       = 1'b1;
                tm_wdata    = tm_new;
                state_next  = S_FIN;
            end
            S_DEQ1: begin
                t_next     = ring_rdata;
                tm_raddr   = ring_rdata;
                state_next = S_DEQ2;
            end
            S_DEQ2: begin
                slot_next  = tm_rdata.head;
                state_next = S_DEQ3;
            end
            S_DEQ3: begin
                tm_new.head = sn_rdata;
                tm_new.size = size_dec;
                tm_we       = 1'b1;
                tm_wdata    = tm_new;
                fs_we       = 1'b1;
                rcount_next = rcount_reg + 1'b1;
                if (size_dec == '0) begin
                    ohead_next  = (ohead_reg == TW'(NUM_TEAMS - 1)) ? '0 : ohead_reg + 1'b1;
                    ocount_next = ocount_reg - 1'b1;
                end
                res_next.valid   = 1'b1;
                res_next.element = se_rdata;
                state_next       = S_FIN;
            end
            S_FIN: begin
                if (out_can_load) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_SWEEP;
            sweep_reg  <= '0;
            report_reg <= 1'b0;
            fresh_reg  <= '0;
            rcount_reg <= '0;
            ohead_reg  <= '0;
            otail_reg  <= '0;
            ocount_reg <= '0;
        end else begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            report_reg <= report_next;
            fresh_reg  <= fresh_next;
            rcount_reg <= rcount_next;
            ohead_reg  <= ohead_next;
            otail_reg  <= otail_next;
            ocount_reg <= ocount_next;
        end
        t_reg    <= t_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
        if (accept) begin
            elem_reg    <= in_elem;
            elem_ok_reg <= in_elem_ok;
        end
        if (state_reg == S_DEQ2) begin
            tw_reg <= tm_rdata;
        end
    end

    // Membership map.
    always_ff @(posedge aclk) begin
        if (toe_we) begin
            toe_mem[toe_waddr] <= toe_wdata;
        end
        toe_rdata <= toe_mem[EW'(in_elem)];
    end

    // Free stack of returned slots.
    always_ff @(posedge aclk) begin
        if (fs_we) begin
            fs_mem[rcount_reg[SW-1:0]] <= slot_reg;
        end
        fs_rdata <= fs_mem[rcount_reg[SW-1:0] - 1'b1];
    end

    // Slot element and link memories.
    always_ff @(posedge aclk) begin
        if (se_we) begin
            se_mem[slot_reg] <= elem_reg;
        end
        se_rdata <= se_mem[tm_rdata.head];
    end

    always_ff @(posedge aclk) begin
        if (sn_we) begin
            sn_mem[sn_waddr] <= slot_reg;
        end
        sn_rdata <= sn_mem[tm_rdata.head];
    end

    // Team table.
    always_ff @(posedge aclk) begin
        if (tm_we) begin
            tm_mem[tm_waddr] <= tm_wdata;
        end
        tm_rdata <= tm_mem[tm_raddr];
    end

    // Team-order ring.
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[otail_reg] <= t_reg;
        end
        ring_rdata <= ring_mem[ohead_reg];
    end

    gfq_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .result   (res_reg),
        .can_load (out_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTH
    a_ring_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ocount_reg) <= NUM_TEAMS)
        else $error("team ring count exceeds the number of teams");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rcount_reg <= fresh_reg)
        else $error("free stack holds more slots than were ever handed out");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (ocount_reg == '0) |-> (ohead_reg == otail_reg))
        else $error("empty team ring with unequal pointers");

    a_empty_deq: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_req == gfq_pkg::REQ_DEQUEUE && ocount_reg == '0)
        |=> (state_reg == S_FIN && res_reg.status == gfq_pkg::STAT_EMPTY))
        else $error("dequeue from an empty queue did not report empty");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for grouped_fifo_team_queue_top: directed table, random mix.
// Depends on gfq_pkg and on the RTL of the block; reads no files.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ELEM     = 4096;
    localparam int N_TEAM     = 256;
    localparam int STORE_CAP  = 4096;
    localparam int RAND_ITEMS = 630;
    localparam int CYCLE_CAP  = 1_000_000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    grouped_fifo_team_queue_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Shadow of the block: membership map, one queue of element ids per team,
    // and the order in which non-empty teams are served.
    logic [gfq_pkg::TEAM_W-1:0] membership [N_ELEM];
    logic [gfq_pkg::ELEM_W-1:0] team_members [N_TEAM][$];
    logic [gfq_pkg::TEAM_W-1:0] team_order [$];
    int                         stored_count;

    // Results still owed by the block, oldest first.
    gfq_pkg::result_t pending_results [$];

    int errors = 0;
    int n_enq = 0, n_deq = 0, n_full = 0, n_empty = 0, n_clear = 0, n_assign = 0;
    int burst_left = 0;
    longint cycles = 0;

    function automatic void wipe_queue_state();
        foreach (membership[i]) membership[i] = '0;
        foreach (team_members[i]) team_members[i].delete();
        team_order.delete();
        stored_count = 0;
    endfunction

    // Applies one request to the shadow and returns the result it should give.
    function automatic gfq_pkg::result_t apply_request(logic [gfq_pkg::REQ_W-1:0] req,
                                                       logic [gfq_pkg::ELEM_W-1:0] elem,
                                                       logic [gfq_pkg::TEAM_W-1:0] team);
        gfq_pkg::result_t           r;
        logic [gfq_pkg::TEAM_W-1:0] t;
        r.valid   = 1'b0;
        r.element = '0;
        r.status  = gfq_pkg::STAT_OK;
        case (req)
            gfq_pkg::REQ_ASSIGN: begin
                membership[elem] = team;
                n_assign++;
            end
            gfq_pkg::REQ_ENQUEUE: begin
                if (stored_count == STORE_CAP) begin
                    r.status = gfq_pkg::STAT_FULL;
                    n_full++;
                end else begin
                    t = membership[elem];
                    if (team_members[t].size() == 0) team_order.push_back(t);
                    team_members[t].push_back(elem);
                    stored_count++;
                    n_enq++;
                end
            end
            gfq_pkg::REQ_DEQUEUE: begin
                if (team_order.size() == 0) begin
                    r.status = gfq_pkg::STAT_EMPTY;
                    n_empty++;
                end else begin
                    t = team_order[0];
                    r.valid   = 1'b1;
                    r.element = team_members[t].pop_front();
                    stored_count--;
                    if (team_members[t].size() == 0) void'(team_order.pop_front());
                    n_deq++;
                end
            end
            default: begin
                wipe_queue_state();
                n_clear++;
            end
        endcase
        return r;
    endfunction

    // Offers one beat and holds it until taken. The sender runs in bursts; valid is
    // only lowered when a gap follows, so it never drops and rises in one step.
    task automatic offer_request(logic [gfq_pkg::REQ_W-1:0] req,
                                 logic [gfq_pkg::ELEM_W-1:0] elem,
                                 logic [gfq_pkg::TEAM_W-1:0] team, bit has_fixed,
                                 gfq_pkg::result_t fixed);
        gfq_pkg::result_t predicted;
        int               gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, team, elem, req};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_request(req, elem, team);
        pending_results.push_back(has_fixed ? fixed : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 10);
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic offer_checked(logic [gfq_pkg::REQ_W-1:0] req,
                                 logic [gfq_pkg::ELEM_W-1:0] elem,
                                 logic [gfq_pkg::TEAM_W-1:0] team);
        offer_request(req, elem, team, 1'b0, '0);
    endtask

    // The receiver changes its habit in turn, driven by the cycle count: always ready,
    // coin toss, mostly stalled, or long stretches of stall.
    always @(posedge aclk) begin
        case ((cycles / 128) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((cycles / 16) % 2 == 0);
        endcase
    end

    // Result checker: every accepted result beat is matched against the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        gfq_pkg::result_t want;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat %h arrived with nothing expected", $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.valid) begin
                    $display("%0t: out_valid expected %0d, got %0d", $time,
                             want.valid, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[12:1] !== want.element) begin
                    $display("%0t: out_element expected %0d, got %0d", $time,
                             want.element, m_tdata[12:1]);
                    errors++;
                end
                if (m_tdata[14:13] !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time,
                             want.status, m_tdata[14:13]);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("%0t: run stopped at the cycle limit", $time);
            $display("tb_top failed");
            $finish;
        end
    end

    typedef struct {
        logic [gfq_pkg::REQ_W-1:0]  req;
        logic [gfq_pkg::ELEM_W-1:0] elem;
        logic [gfq_pkg::TEAM_W-1:0] team;
        bit                         has_fixed;
        gfq_pkg::result_t           fixed;
    } stim_row_t;

    localparam gfq_pkg::result_t R_OK    = '{status: gfq_pkg::STAT_OK,    element: '0,
                                             valid: 1'b0};
    localparam gfq_pkg::result_t R_EMPTY = '{status: gfq_pkg::STAT_EMPTY, element: '0,
                                             valid: 1'b0};

    // Directed rows: an empty dequeue straight after reset, extreme ids and
    // teams, alternating bit patterns, interleaved teams, clear with data held,
    // and membership returning to team 0 after a clear.
    stim_row_t directed [] = '{
        '{gfq_pkg::REQ_DEQUEUE, 12'd0,    8'd0,    1'b1, R_EMPTY},
        '{gfq_pkg::REQ_ENQUEUE, 12'd0,    8'd0,    1'b1, R_OK},
        '{gfq_pkg::REQ_ASSIGN,  12'd4095, 8'd255,  1'b1, R_OK},
        '{gfq_pkg::REQ_ENQUEUE, 12'd4095, 8'd0,    1'b1, R_OK},
        '{gfq_pkg::REQ_ASSIGN,  12'd1,    8'd255,  1'b1, R_OK},
        '{gfq_pkg::REQ_ENQUEUE, 12'd1,    8'd0,    1'b0, R_OK},
        '{gfq_pkg::REQ_ENQUEUE, 12'd2,    8'd0,    1'b0, R_OK},
        '{gfq_pkg::REQ_ASSIGN,  12'h555,  8'hAA,   1'b0, R_OK},
        '{gfq_pkg::REQ_ENQUEUE, 12'h555,  8'h55,   1'b0, R_OK},
        '{gfq_pkg::REQ_ASSIGN,  12'hAAA,  8'h55,   1'b0, R_OK},
        '{gfq_pkg::REQ_ENQUEUE, 12'hAAA,  8'hFF,   1'b0, R_OK},
        '{gfq_pkg::REQ_DEQUEUE, 12'd0,    8'd0,    1'b0, R_OK},
        '{gfq_pkg::REQ_DEQUEUE, 12'd0,    8'd0,    1'b0, R_OK},
        '{gfq_pkg::REQ_DEQUEUE, 12'd0,    8'd0,    1'b0, R_OK},
        '{gfq_pkg::REQ_DEQUEUE, 12'd0,    8'd0,    1'b0, R_OK},
        '{gfq_pkg::REQ_DEQUEUE, 12'd0,    8'd0,    1'b0, R_OK},
        '{gfq_pkg::REQ_DEQUEUE, 12'd0,    8'd0,    1'b0, R_OK},
        '{gfq_pkg::REQ_DEQUEUE, 12'd0,    8'd0,    1'b1, R_EMPTY},
        '{gfq_pkg::REQ_ENQUEUE, 12'd7,    8'd0,    1'b1, R_OK},
        '{gfq_pkg::REQ_CLEAR,   12'hFFF,  8'hFF,   1'b1, R_OK},
        '{gfq_pkg::REQ_DEQUEUE, 12'd0,    8'd0,    1'b1, R_EMPTY},
        '{gfq_pkg::REQ_ENQUEUE, 12'd4095, 8'd0,    1'b1, R_OK},
        '{gfq_pkg::REQ_DEQUEUE, 12'd0,    8'd0,    1'b1,
          '{status: gfq_pkg::STAT_OK, element: 12'd4095, valid: 1'b1}}
    };

    initial begin
        int pick;
        logic [gfq_pkg::ELEM_W-1:0] e;
        logic [gfq_pkg::TEAM_W-1:0] tm;
        wipe_queue_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            offer_request(directed[i].req, directed[i].elem, directed[i].team,
                          directed[i].has_fixed, directed[i].fixed);

        // Random mix. Ids come mostly from a small pool so that teams gather
        // several members and sub-queues grow and drain repeatedly.
        for (int i = 0; i < RAND_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            e = ($urandom_range(0, 3) == 0) ? gfq_pkg::ELEM_W'($urandom_range(0, 4095))
                                            : gfq_pkg::ELEM_W'($urandom_range(0, 31));
            tm = gfq_pkg::TEAM_W'($urandom_range(0, 255));
            if (pick < 20)
                offer_checked(gfq_pkg::REQ_ASSIGN, e,
                              ($urandom_range(0, 1) ? tm
                                                    : gfq_pkg::TEAM_W'($urandom_range(0, 5))));
            else if (pick < 60)
                offer_checked(gfq_pkg::REQ_ENQUEUE, e, tm);
            else if (pick < 98)
                offer_checked(gfq_pkg::REQ_DEQUEUE,
                              gfq_pkg::ELEM_W'($urandom_range(0, 4095)), tm);
            else
                offer_checked(gfq_pkg::REQ_CLEAR,
                              gfq_pkg::ELEM_W'($urandom_range(0, 4095)), tm);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered %0d enqueues, %0d dequeues, %0d assigns and %0d clears;",
                 n_enq, n_deq, n_assign, n_clear);
        $display("storage full hit %0d times, empty dequeue %0d times.", n_full, n_empty);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
